FILE: src/bmsa_pkg.sv
package bmsa_pkg;

    localparam int WordBits    = 64;
    localparam int BitW        = 6;
    localparam int ResultLimit = 16;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_GRANTED      = 2'd0,
        ST_REJECTED     = 2'd1,
        ST_RELEASED     = 2'd2,
        ST_FREE_RELEASE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_SCAN,
        S_REL,
        S_REJ
    } t_state;

    // lowest free bit of a bitmap word
    typedef struct packed {
        logic            found;
        logic [BitW-1:0] idx;
    } t_find;

endpackage

FILE: src/bmsa_if.sv
interface bmsa_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [4:0] slot_count;
    logic [9:0] slot_id;

    modport source(output valid, output opcode, output slot_count, output slot_id,
                   input ready);
    modport sink(input valid, input opcode, input slot_count, input slot_id,
                 output ready);
endinterface

interface bmsa_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] slot_number;
    logic [3:0] slot_index;
    logic [1:0] status;
    logic       last;

    modport source(output valid, output slot_number, output slot_index,
                   output status, output last, input ready);
    modport sink(input valid, input slot_number, input slot_index,
                 input status, input last, output ready);
endinterface

FILE: src/bmsa_ram.sv
module bmsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bmsa_find.sv
module bmsa_find import bmsa_pkg::*; (
    input  logic [WordBits-1:0] i_word,
    output t_find               o_find
);

    logic [WordBits-1:0] free_bits;
    logic [WordBits-1:0] low_bit;
    logic [BitW-1:0]     idx;

    // isolate the lowest zero of the word, then OR-encode its position
    always_comb begin
        free_bits = ~i_word;
        low_bit   = free_bits & (i_word + WordBits'(1));
        idx       = '0;
        for (int b = 0; b < WordBits; b++) begin
            if (low_bit[b]) begin
                idx = idx | BitW'(b);
            end
        end
        o_find.found = |free_bits;
        o_find.idx   = idx;
    end

endmodule

FILE: src/bitmap_multi_slot_allocator.sv
// Allocate: accept in idle, then for each bitmap word visited a read and a load state,
//   plus a scan state per full word skipped and per granted slot.
// Release: read, load, then free; a rejected allocate goes to reject; emits wait out stalls.
// One request is worked at a time; a new one is taken while the last word waits to go.
// Synchronous active-low reset: every slot free, no words pending; bitmap RAM
//   entries read as zero until first written (per-entry valid flops).
module bitmap_multi_slot_allocator import bmsa_pkg::*; #(
    parameter int SLOT_TOTAL  = 1024,
    parameter int MAX_REQUEST = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bmsa_in_if.sink         i_in,
    bmsa_out_if.source      o_out
);

    localparam int MapWords = (SLOT_TOTAL + WordBits - 1) / WordBits;
    localparam int AW       = MapWords > 1 ? $clog2(MapWords) : 1;
    localparam int FW       = $clog2(SLOT_TOTAL + 1);
    localparam int Rem      = SLOT_TOTAL % WordBits;
    localparam logic [WordBits-1:0] LastPad =
        (Rem == 0) ? '0 : ~((WordBits'(1) << Rem) - WordBits'(1));

    t_state r_state, n_state;

    logic [AW-1:0]        r_word, n_word;
    logic [WordBits-1:0]  r_cur, n_cur;
    logic [4:0]           r_got, n_got;
    logic [4:0]           r_want, n_want;
    logic [FW-1:0]        r_free, n_free;
    logic [9:0]           r_slot_id, n_slot_id;
    logic                 r_range, n_range;
    logic [MapWords-1:0]  r_vld;

    logic                 r_out_vld;
    logic [9:0]           r_out_num;
    logic [3:0]           r_out_idx;
    t_status              r_out_st;
    logic                 r_out_last;

    logic                 emit;
    logic [9:0]           e_num;
    logic [3:0]           e_idx;
    t_status              e_st;
    logic                 e_last;

    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [WordBits-1:0]  ram_wdata;
    logic [WordBits-1:0]  ram_rdata;

    logic                 in_acc;
    logic                 out_ld;
    logic                 reject;
    logic                 grant_last;
    logic [WordBits-1:0]  pad;
    logic [WordBits-1:0]  grant_bit;
    logic [WordBits-1:0]  rel_bit;
    t_find                fnd;

    bmsa_ram #(
        .WIDTH(WordBits),
        .DEPTH(MapWords)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_word),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    bmsa_find u_find (
        .i_word(r_cur),
        .o_find(fnd)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_ld     = !r_out_vld || o_out.ready;

    assign reject = (i_in.slot_count == 5'd0)
                 || (7'(i_in.slot_count) > 7'(MAX_REQUEST))
                 || (7'(i_in.slot_count) > 7'(ResultLimit))
                 || (FW'(i_in.slot_count) > r_free);

    // slots past SLOT_TOTAL in the last word count as taken
    assign pad        = (32'(r_word) == MapWords - 1) ? LastPad : '0;
    assign grant_bit  = WordBits'(1) << fnd.idx;
    assign rel_bit    = WordBits'(1) << r_slot_id[BitW-1:0];
    assign grant_last = (r_got + 5'd1 == r_want);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.opcode == OP_RELEASE) begin
                        n_state = S_RD;
                    end else if (reject) begin
                        n_state = S_REJ;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:   n_state = S_LOAD;
            S_LOAD: n_state = (r_want == 5'd0) ? S_REL : S_SCAN;
            S_SCAN: begin
                if (!fnd.found) begin
                    n_state = S_RD;
                end else if (out_ld) begin
                    if (grant_last) begin
                        n_state = S_IDLE;
                    end else if ((r_cur | grant_bit) == '1) begin
                        n_state = S_RD;
                    end
                end
            end
            S_REL:  if (out_ld) n_state = S_IDLE;
            S_REJ:  if (out_ld) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_word    = r_word;
        n_cur     = r_cur;
        n_got     = r_got;
        n_want    = r_want;
        n_free    = r_free;
        n_slot_id = r_slot_id;
        n_range   = r_range;
        emit      = 1'b0;
        e_num     = '0;
        e_idx     = '0;
        e_st      = ST_GRANTED;
        e_last    = 1'b1;
        ram_we    = 1'b0;
        ram_raddr = r_word;
        ram_wdata = r_cur;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_slot_id = i_in.slot_id;
                    n_got     = '0;
                    if (i_in.opcode == OP_RELEASE) begin
                        // want of zero marks the release path
                        n_want  = '0;
                        n_word  = AW'(i_in.slot_id >> BitW);
                        n_range = 17'(i_in.slot_id) < 17'(SLOT_TOTAL);
                    end else begin
                        n_want  = i_in.slot_count;
                        n_word  = '0;
                        n_range = 1'b1;
                    end
                end
            end
            S_RD: begin
                ram_raddr = r_word;
            end
            S_LOAD: begin
                n_cur = (r_range && r_vld[r_word]) ? ram_rdata : '0;
                if (r_want != 5'd0) begin
                    n_cur = n_cur | pad;
                end
            end
            S_SCAN: begin
                if (!fnd.found) begin
                    n_word = r_word + AW'(1);
                end else if (out_ld) begin
                    emit   = 1'b1;
                    e_num  = 10'({r_word, fnd.idx});
                    e_idx  = r_got[3:0];
                    e_st   = ST_GRANTED;
                    e_last = grant_last;
                    n_cur  = r_cur | grant_bit;
                    n_got  = r_got + 5'd1;
                    if (grant_last || n_cur == '1) begin
                        ram_we    = 1'b1;
                        ram_wdata = n_cur;
                    end
                    if (grant_last) begin
                        n_free = r_free - FW'(r_want);
                    end else if (n_cur == '1) begin
                        n_word = r_word + AW'(1);
                    end
                end
            end
            S_REL: begin
                if (out_ld) begin
                    emit  = 1'b1;
                    e_num = r_slot_id;
                    if (r_range && (r_cur & rel_bit) != '0) begin
                        e_st      = ST_RELEASED;
                        ram_we    = 1'b1;
                        ram_wdata = r_cur & ~rel_bit;
                        n_free    = r_free + FW'(1);
                    end else begin
                        e_st = ST_FREE_RELEASE;
                    end
                end
            end
            S_REJ: begin
                if (out_ld) begin
                    emit = 1'b1;
                    e_st = ST_REJECTED;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_free    <= FW'(SLOT_TOTAL);
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            if (ram_we) begin
                r_vld[r_word] <= 1'b1;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_cur     <= n_cur;
        r_got     <= n_got;
        r_want    <= n_want;
        r_slot_id <= n_slot_id;
        r_range   <= n_range;
        if (emit) begin
            r_out_num  <= e_num;
            r_out_idx  <= e_idx;
            r_out_st   <= e_st;
            r_out_last <= e_last;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.slot_number = r_out_num;
    assign o_out.slot_index  = r_out_idx;
    assign o_out.status      = r_out_st;
    assign o_out.last        = r_out_last;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FW'(SLOT_TOTAL))
        else $error("free count above slot total");

    a_grant_free_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && emit) |-> (r_cur & grant_bit) == '0)
        else $error("granted a slot already in use");

    a_grant_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && emit) |=> r_got == $past(r_got) + 5'd1)
        else $error("grant count did not advance");

    a_single_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("second request taken while one is in work");

    a_done_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && n_state == S_IDLE) |-> (emit && e_last))
        else $error("request finished without a last word");

endmodule

FILE: sim/bmsa_slot_checker.sv
`timescale 1ns / 1ps

module bmsa_slot_checker import bmsa_pkg::*; #(
    parameter int SLOT_TOTAL  = 1024,
    parameter int MAX_REQUEST = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmsa_in_if         i_req,
    bmsa_out_if        i_res,
    output int         o_mismatches,
    output int         o_pending
);

    localparam int MapWords = (SLOT_TOTAL + WordBits - 1) / WordBits;

    typedef struct packed {
        logic [9:0] number;
        logic [3:0] index;
        t_status    status;
        logic       last;
    } t_slot_word;

    logic [WordBits-1:0] used_map [MapWords];
    int                  free_slots;
    t_slot_word          pending_results [$];
    int                  mismatch_cnt = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // all or nothing: a request that cannot be met leaves the map alone
    function automatic void grant_slots(input int want);
        t_slot_word w;
        int         got;
        int         s;
        got = 0;
        if (want == 0 || want > MAX_REQUEST || want > ResultLimit || want > free_slots) begin
            w.number = '0;
            w.index  = '0;
            w.status = ST_REJECTED;
            w.last   = 1'b1;
            pending_results.push_back(w);
            return;
        end
        // lowest free bits first; skipping full words gives the same order
        for (s = 0; s < SLOT_TOTAL && got < want; s++) begin
            if (!used_map[s / WordBits][s % WordBits]) begin
                used_map[s / WordBits][s % WordBits] = 1'b1;
                w.number = s[9:0];
                w.index  = got[3:0];
                w.status = ST_GRANTED;
                w.last   = (got + 1 == want);
                pending_results.push_back(w);
                got++;
            end
        end
        free_slots -= got;
    endfunction

    function automatic void free_slot(input logic [9:0] id);
        t_slot_word w;
        int         s;
        s        = int'(id);
        w.number = id;
        w.index  = '0;
        w.last   = 1'b1;
        if (s >= SLOT_TOTAL || !used_map[s / WordBits][s % WordBits]) begin
            w.status = ST_FREE_RELEASE;
        end else begin
            used_map[s / WordBits][s % WordBits] = 1'b0;
            free_slots++;
            w.status = ST_RELEASED;
        end
        pending_results.push_back(w);
    endfunction

    function automatic void check_field(input string name, input logic [9:0] exp_v,
                                        input logic [9:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_slot_word want_w;
        if (!i_rst_n) begin
            for (int k = 0; k < MapWords; k++) used_map[k] = '0;
            free_slots = SLOT_TOTAL;
            pending_results.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                if (i_req.opcode == OP_ALLOC) grant_slots(int'(i_req.slot_count));
                else free_slot(i_req.slot_id);
            end
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual slot %0d idx %0d st %0d last %0d",
                             $time, i_res.slot_number, i_res.slot_index, i_res.status,
                             i_res.last);
                    mismatch_cnt++;
                end else begin
                    want_w = pending_results.pop_front();
                    check_field("slot_number", want_w.number, i_res.slot_number);
                    check_field("slot_index", want_w.index, i_res.slot_index);
                    check_field("status", want_w.status, i_res.status);
                    check_field("last", want_w.last, i_res.last);
                end
            end
        end
        o_pending    <= pending_results.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

FILE: sim/tb_bitmap_multi_slot_allocator.sv
`timescale 1ns / 1ps

module tb_bitmap_multi_slot_allocator;
    import bmsa_pkg::*;

    localparam int SLOT_TOTAL  = 1024;
    localparam int MAX_REQUEST = 16;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    bit   idle_on;
    int   stall_left;
    bit   held [SLOT_TOTAL];

    bmsa_in_if  req_ch();
    bmsa_out_if res_ch();

    bitmap_multi_slot_allocator #(
        .SLOT_TOTAL (SLOT_TOTAL),
        .MAX_REQUEST(MAX_REQUEST)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (res_ch)
    );

    bmsa_slot_checker #(
        .SLOT_TOTAL (SLOT_TOTAL),
        .MAX_REQUEST(MAX_REQUEST)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_res       (res_ch),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        idle_on            = 1'b1;
        stall_left         = 0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_ALLOC;
        req_ch.slot_count  = '0;
        req_ch.slot_id     = '0;
        res_ch.ready       = 1'b0;
        for (int k = 0; k < SLOT_TOTAL; k++) held[k] = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    // result side backpressure in random-length bursts, started only while idle_on is set
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 6);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // track which slots the block has handed out, to aim releases
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (res_ch.status == ST_GRANTED) held[res_ch.slot_number] <= 1'b1;
            else if (res_ch.status == ST_RELEASED) held[res_ch.slot_number] <= 1'b0;
        end
    end

    task automatic issue_request(input t_opcode op, input logic [4:0] cnt,
                                 input logic [9:0] id);
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.slot_count <= cnt;
        req_ch.slot_id    <= id;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    function automatic logic [9:0] pick_held_slot();
        int start;
        int s;
        start = $urandom_range(0, SLOT_TOTAL - 1);
        for (int k = 0; k < SLOT_TOTAL; k++) begin
            s = (start + k) % SLOT_TOTAL;
            if (held[s]) return s[9:0];
        end
        return start[9:0];
    endfunction

    // mostly well-formed traffic, a few malformed counts and blind releases
    task automatic random_request(input int alloc_pct, input int min_cnt);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            issue_request(OP_ALLOC, ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(17, 31)),
                          10'($urandom_range(0, 1023)));
        end else if (r < 6) begin
            issue_request(OP_RELEASE, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)));
        end else if (r < 6 + alloc_pct) begin
            issue_request(OP_ALLOC, 5'($urandom_range(min_cnt, MAX_REQUEST)),
                          10'($urandom_range(0, 1023)));
        end else begin
            issue_request(OP_RELEASE, 5'($urandom_range(0, 31)), pick_held_slot());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_request(OP_ALLOC, 5'd0, 10'd0);        // zero count
        issue_request(OP_ALLOC, 5'd31, 10'd1023);    // oversized count
        issue_request(OP_ALLOC, 5'd17, 10'd0);
        issue_request(OP_ALLOC, 5'd1, 10'd0);
        issue_request(OP_ALLOC, 5'd16, 10'd0);
        issue_request(OP_RELEASE, 5'd0, 10'd5);
        issue_request(OP_RELEASE, 5'd0, 10'd5);      // already free
        issue_request(OP_RELEASE, 5'd31, 10'd1023);  // never used
        issue_request(OP_ALLOC, 5'd3, 10'd682);      // fills the hole first
        issue_request(OP_ALLOC, 5'd16, 10'd341);
        issue_request(OP_ALLOC, 5'd16, 10'd0);
        issue_request(OP_ALLOC, 5'd16, 10'd0);       // crosses into word 1
        issue_request(OP_RELEASE, 5'd0, 10'd0);
        issue_request(OP_RELEASE, 5'd0, 10'd63);
        issue_request(OP_ALLOC, 5'd2, 10'd0);
        issue_request(OP_RELEASE, 5'd0, 10'd64);
        issue_request(OP_ALLOC, 5'd1, 10'd0);        // word 0 full, skipped
        issue_request(OP_ALLOC, 5'd16, 10'd512);

        // fill the map until requests no longer fit
        for (int n = 0; n < 100; n++) random_request(90, 10);

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 150; n++) begin
            if (n % 30 == 0) idle_on <= ($urandom_range(0, 1) != 0);
            random_request(42, 1);
        end

        idle_on <= 1'b1;
        for (int n = 0; n < 100; n++) begin
            if (n == 60) idle_on <= 1'b0;
            random_request(28, 1);
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/bmsa_pkg.sv
src/bmsa_if.sv
src/bmsa_ram.sv
src/bmsa_find.sv
src/bitmap_multi_slot_allocator.sv
sim/bmsa_slot_checker.sv
sim/tb_bitmap_multi_slot_allocator.sv
